// ===== rtl/ubm_pkg.sv =====
// usage map checker package: entry codes, command codes, register indexes
// and fixed widths shared by the map fill logic and the top level
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ubm_pkg;

    // widths fixed by the item and register fields
    localparam int CODE_W  = 3;
    localparam int START_W = 16;
    localparam int SIZE_W  = 4;
    localparam int TOTAL_W = 13;
    localparam int DIR_W   = 12;
    localparam int CFG_W   = 13;
    localparam int RUN_W   = 16;
    // block numbers during a run reach past a 16-bit start
    localparam int EXT_W   = 17;

    typedef logic [CODE_W-1:0] code_t;
    typedef logic [1:0]        cmd_t;
    typedef logic [1:0]        cfg_idx_t;

    localparam code_t CODE_BLANK  = 3'd0;
    localparam code_t CODE_FREE   = 3'd1;
    localparam code_t CODE_USED   = 3'd2;
    localparam code_t CODE_MULTI  = 3'd3;
    localparam code_t CODE_SYSTEM = 3'd4;
    localparam code_t CODE_DIR    = 3'd5;
    localparam code_t CODE_TEST   = 3'd6;

    localparam cmd_t CMD_CLEAR = 2'd0;
    localparam cmd_t CMD_MARK  = 2'd1;
    localparam cmd_t CMD_READ  = 2'd2;

    localparam cfg_idx_t CFG_TOTAL_BLOCKS = 2'd0;
    localparam cfg_idx_t CFG_DIR_START    = 2'd1;
    localparam cfg_idx_t CFG_DIR_LENGTH   = 2'd2;

    localparam logic [TOTAL_W-1:0] TOTAL_BLOCKS_RST = 13'd4096;

endpackage

`default_nettype wire

// ===== rtl/ubm_map_ram.sv =====
// usage map storage: one write port, one read port, registered read data
// depends on ubm_pkg for the entry code type
`timescale 1ns / 1ps
`default_nettype none

module ubm_map_ram #(
    parameter int MAP_ENTRIES = 4096,
    parameter int AW          = 12
) (
    input  wire logic            clk,
    input  wire logic            we,
    input  wire logic [AW-1:0]   waddr,
    input  wire ubm_pkg::code_t  wdata,
    input  wire logic [AW-1:0]   raddr,
    output ubm_pkg::code_t       rdata
);

    ubm_pkg::code_t mem [MAP_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/ubm_fill_code.sv =====
// code that a clear command writes into one map entry, and the range flag
// of the clear; depends on ubm_pkg
`timescale 1ns / 1ps
`default_nettype none

module ubm_fill_code #(
    parameter int MAP_ENTRIES = 4096,
    parameter int AW          = 12
) (
    input  wire logic [AW-1:0]                idx,
    input  wire logic [ubm_pkg::TOTAL_W-1:0]  total_blocks,
    input  wire logic [ubm_pkg::DIR_W-1:0]    dir_start,
    input  wire logic [ubm_pkg::DIR_W-1:0]    dir_length,
    output ubm_pkg::code_t                    code,
    output logic                              clear_oor
);

    localparam logic [ubm_pkg::EXT_W-1:0] MAP_EXT = ubm_pkg::EXT_W'(MAP_ENTRIES);

    logic [ubm_pkg::EXT_W-1:0] idx_ext;
    logic [ubm_pkg::EXT_W-1:0] tot_ext;
    logic [ubm_pkg::EXT_W-1:0] ds_ext;
    logic [ubm_pkg::EXT_W-1:0] dir_end;
    logic                      dir_any;

    assign idx_ext = ubm_pkg::EXT_W'(idx);
    assign tot_ext = ubm_pkg::EXT_W'(total_blocks);
    assign ds_ext  = ubm_pkg::EXT_W'(dir_start);
    assign dir_end = ds_ext + ubm_pkg::EXT_W'(dir_length);
    assign dir_any = (dir_length != '0);

    // directory wins over system, system over test track, test over free
    always_comb
    begin
        if (dir_any && (idx_ext >= ds_ext) && (idx_ext < dir_end))
        begin
            code = ubm_pkg::CODE_DIR;
        end
        else if (idx == '0)
        begin
            code = ubm_pkg::CODE_SYSTEM;
        end
        else if ((total_blocks != '0) && (idx_ext == tot_ext - ubm_pkg::EXT_W'(1)))
        begin
            code = ubm_pkg::CODE_TEST;
        end
        else if (idx_ext < tot_ext)
        begin
            code = ubm_pkg::CODE_FREE;
        end
        else
        begin
            code = ubm_pkg::CODE_BLANK;
        end
    end

    assign clear_oor = (tot_ext > MAP_EXT) || (dir_any && (dir_end > MAP_EXT));

endmodule

`default_nettype wire

// ===== rtl/block_usage_map_checker.sv =====
// block usage map checker top level: command sequencer, geometry registers
// and result register; uses ubm_pkg, ubm_map_ram and ubm_fill_code
//
//  channel   signals                                   direction  width
//  item      item_valid/item_ready, cmd, start_block,  in         2/16/4
//            size_code
//  result    result_valid/result_ready, entry_code,    out        3/1/1
//            collision, out_of_range
//  config    cfg_we, cfg_index, cfg_data               in         2/13
//
// one item at a time; the map memory port sets the pace at one entry a cycle
// clear: writes the fill code into every map entry; read: one map read at start_block
// mark: reads and writes back each block of the run that lies inside the map
// (run = 2^k >> SECTORS_PER_BLOCK_LOG2)
// after reset all MAP_ENTRIES entries are swept to blank, no item taken
// a stalled result holds the next finished item in the sequencer
`timescale 1ns / 1ps
`default_nettype none

module block_usage_map_checker #(
    parameter int MAP_ENTRIES            = 4096,
    parameter int SECTORS_PER_BLOCK_LOG2 = 4
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              item_valid,
    output logic                                   item_ready,
    input  wire logic [1:0]                        cmd,
    input  wire logic [ubm_pkg::START_W-1:0]       start_block,
    input  wire logic [ubm_pkg::SIZE_W-1:0]        size_code,
    output logic                                   result_valid,
    input  wire logic                              result_ready,
    output logic [2:0]                             entry_code,
    output logic                                   collision,
    output logic                                   out_of_range,
    input  wire logic                              cfg_we,
    input  wire logic [1:0]                        cfg_index,
    input  wire logic [ubm_pkg::CFG_W-1:0]         cfg_data
);

    localparam int AW = $clog2(MAP_ENTRIES);
    localparam logic [ubm_pkg::EXT_W-1:0] MAP_EXT  = ubm_pkg::EXT_W'(MAP_ENTRIES);
    localparam logic [AW-1:0]             LAST_IDX = AW'(MAP_ENTRIES - 1);

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_CLEAR  = 3'd2;
    localparam logic [2:0] ST_MARK   = 3'd3;
    localparam logic [2:0] ST_RDREQ  = 3'd4;
    localparam logic [2:0] ST_RDWAIT = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    logic [2:0] state_reg, state_next;

    logic [ubm_pkg::TOTAL_W-1:0] total_blocks_reg;
    logic [ubm_pkg::DIR_W-1:0]   dir_start_reg;
    logic [ubm_pkg::DIR_W-1:0]   dir_length_reg;

    logic [AW-1:0]               cnt_reg, cnt_next;
    logic [ubm_pkg::START_W-1:0] start_reg, start_next;
    logic [ubm_pkg::EXT_W-1:0]   rd_addr_reg, rd_addr_next;
    logic [ubm_pkg::RUN_W-1:0]   left_reg, left_next;
    logic                        pend_reg, pend_next;
    logic [AW-1:0]               pend_addr_reg, pend_addr_next;

    ubm_pkg::code_t code_reg, code_next;
    logic           coll_reg, coll_next;
    logic           oor_reg, oor_next;

    logic           result_valid_reg, result_valid_next;
    ubm_pkg::code_t entry_code_reg, entry_code_next;
    logic           collision_reg, collision_next;
    logic           out_of_range_reg, out_of_range_next;

    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    ubm_pkg::code_t mem_wdata;
    logic [AW-1:0]  mem_raddr;
    ubm_pkg::code_t mem_rdata;

    ubm_pkg::code_t fill_code;
    logic           clear_oor;

    logic [ubm_pkg::RUN_W-1:0] run_len;
    logic                      start_oob;
    logic                      start_in_map;
    logic                      rd_in_map;
    logic                      issue;
    logic                      load;

    ubm_map_ram #(
        .MAP_ENTRIES (MAP_ENTRIES),
        .AW          (AW)
    ) u_map_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    ubm_fill_code #(
        .MAP_ENTRIES (MAP_ENTRIES),
        .AW          (AW)
    ) u_fill_code (
        .idx          (cnt_reg),
        .total_blocks (total_blocks_reg),
        .dir_start    (dir_start_reg),
        .dir_length   (dir_length_reg),
        .code         (fill_code),
        .clear_oor    (clear_oor)
    );

    assign run_len = (ubm_pkg::RUN_W'(1) << size_code) >> SECTORS_PER_BLOCK_LOG2;
    assign start_oob    = (ubm_pkg::EXT_W'(start_block) >= MAP_EXT);
    assign start_in_map = (ubm_pkg::EXT_W'(start_reg) < MAP_EXT);
    assign rd_in_map    = (rd_addr_reg < MAP_EXT);
    assign issue        = (left_reg != '0) && rd_in_map;
    assign load         = (state_reg == ST_DONE) && (!result_valid_reg || result_ready);

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = result_valid_reg;
    assign entry_code   = entry_code_reg;
    assign collision    = collision_reg;
    assign out_of_range = out_of_range_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        start_next     = start_reg;
        rd_addr_next   = rd_addr_reg;
        left_next      = left_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        code_next      = code_reg;
        coll_next      = coll_reg;
        oor_next       = oor_reg;
        mem_we         = 1'b0;
        mem_waddr      = cnt_reg;
        mem_wdata      = ubm_pkg::CODE_BLANK;
        mem_raddr      = start_reg[AW-1:0];

        case (state_reg)
            ST_INIT:
            begin
                mem_we   = 1'b1;
                cnt_next = cnt_reg + AW'(1);
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    start_next = start_block;
                    code_next  = ubm_pkg::CODE_BLANK;
                    coll_next  = 1'b0;
                    oor_next   = 1'b0;
                    case (cmd)
                        ubm_pkg::CMD_CLEAR:
                        begin
                            oor_next   = clear_oor;
                            cnt_next   = '0;
                            state_next = ST_CLEAR;
                        end
                        ubm_pkg::CMD_MARK:
                        begin
                            oor_next     = start_oob;
                            rd_addr_next = ubm_pkg::EXT_W'(start_block);
                            left_next    = run_len;
                            state_next   = ST_MARK;
                        end
                        ubm_pkg::CMD_READ:
                        begin
                            oor_next   = start_oob;
                            state_next = ST_RDREQ;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_wdata = fill_code;
                cnt_next  = cnt_reg + AW'(1);
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end
            end
            ST_MARK:
            begin
                // read one block ahead while writing back the one read last beat
                if ((left_reg != '0) && !rd_in_map)
                begin
                    oor_next  = 1'b1;
                    left_next = '0;
                end
                if (issue)
                begin
                    mem_raddr      = rd_addr_reg[AW-1:0];
                    rd_addr_next   = rd_addr_reg + ubm_pkg::EXT_W'(1);
                    left_next      = left_reg - ubm_pkg::RUN_W'(1);
                    pend_next      = 1'b1;
                    pend_addr_next = rd_addr_reg[AW-1:0];
                end
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pend_addr_reg;
                    if (mem_rdata == ubm_pkg::CODE_FREE)
                    begin
                        mem_wdata = ubm_pkg::CODE_USED;
                    end
                    else
                    begin
                        mem_wdata = ubm_pkg::CODE_MULTI;
                        coll_next = 1'b1;
                    end
                end
                if (!issue && !pend_reg)
                begin
                    state_next = ST_RDREQ;
                end
            end
            ST_RDREQ:
            begin
                state_next = ST_RDWAIT;
            end
            ST_RDWAIT:
            begin
                code_next  = start_in_map ? mem_rdata : ubm_pkg::CODE_BLANK;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        entry_code_next   = entry_code_reg;
        collision_next    = collision_reg;
        out_of_range_next = out_of_range_reg;
        if (load)
        begin
            result_valid_next = 1'b1;
            entry_code_next   = code_reg;
            collision_next    = coll_reg;
            out_of_range_next = oor_reg;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_INIT;
            cnt_reg          <= '0;
            left_reg         <= '0;
            pend_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
            total_blocks_reg <= ubm_pkg::TOTAL_BLOCKS_RST;
            dir_start_reg    <= '0;
            dir_length_reg   <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            left_reg         <= left_next;
            pend_reg         <= pend_next;
            result_valid_reg <= result_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    ubm_pkg::CFG_TOTAL_BLOCKS:
                    begin
                        total_blocks_reg <= cfg_data[ubm_pkg::TOTAL_W-1:0];
                    end
                    ubm_pkg::CFG_DIR_START:
                    begin
                        dir_start_reg <= cfg_data[ubm_pkg::DIR_W-1:0];
                    end
                    ubm_pkg::CFG_DIR_LENGTH:
                    begin
                        dir_length_reg <= cfg_data[ubm_pkg::DIR_W-1:0];
                    end
                    default:
                    begin
                        dir_length_reg <= dir_length_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        start_reg        <= start_next;
        rd_addr_reg      <= rd_addr_next;
        pend_addr_reg    <= pend_addr_next;
        code_reg         <= code_next;
        coll_reg         <= coll_next;
        oor_reg          <= oor_next;
        entry_code_reg   <= entry_code_next;
        collision_reg    <= collision_next;
        out_of_range_reg <= out_of_range_next;
    end

endmodule

`default_nettype wire
